/* rtl/abkf_pkg.sv */
// ----------------------------------------------------------------------------
// abkf_pkg: shared types and constants of the angle/bias Kalman filter
// Payload structs, controller command/status, micro-op codes, register map.
// ----------------------------------------------------------------------------
package abkf_pkg;

	localparam int FRAC_T  = 16;
	localparam int FRAC_P  = 24;
	localparam int DIGIT_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;

	localparam logic [31:0] ANGLE_NOISE_RST = 32'd16777;
	localparam logic [31:0] BIAS_NOISE_RST  = 32'd50332;
	localparam logic [31:0] MEAS_NOISE_RST  = 32'd503316;

	typedef struct packed {
		logic signed [31:0] measured_angle;
		logic signed [31:0] measured_rate;
		logic        [15:0] step_time;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] filtered_angle;
		logic signed [31:0] estimated_bias;
	} out_item_t;

	// micro-op sequence, run in declaration order
	typedef enum logic [3:0] {
		OP_ANGLE_PRED,
		OP_DP11,
		OP_P00_PRED,
		OP_P11_PRED,
		OP_K0,
		OP_K1,
		OP_A_CORR,
		OP_B_CORR,
		OP_P00_CORR,
		OP_P01_CORR,
		OP_P10_CORR,
		OP_P11_CORR
	} op_t;

	typedef struct packed {
		logic load;
		logic start;
		logic emit;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic done;
	} status_t;

endpackage

/* rtl/abkf_mul.sv */
// ----------------------------------------------------------------------------
// abkf_mul: digit-serial signed multiplier
// Sign-magnitude product, four bits of b per cycle, then round half away from
// zero, shift by 16 or 24 and clamp.
// ----------------------------------------------------------------------------
module abkf_mul #(
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic frac_p,
	input  logic signed [((DATA_WIDTH > 33) ? DATA_WIDTH : 33) + 2:0] a,
	input  logic signed [((DATA_WIDTH > 33) ? DATA_WIDTH : 33) + 2:0] b,
	output logic done,
	output logic signed [((DATA_WIDTH > 33) ? DATA_WIDTH : 33) + 5:0] res
);

	localparam int WW = ((DATA_WIDTH > 33) ? DATA_WIDTH : 33) + 3;
	localparam int RW = WW + 3;
	localparam int ND = (WW + abkf_pkg::DIGIT_W - 1) / abkf_pkg::DIGIT_W;
	localparam int PW = ND * abkf_pkg::DIGIT_W;
	localparam int AW = PW + WW;
	localparam int CW = $clog2(ND + 1);
	localparam logic [AW:0] LIM = (AW+1)'(1) << (WW + 1);
	localparam logic [AW:0] HALF_T = (AW+1)'(1) << (abkf_pkg::FRAC_T - 1);
	localparam logic [AW:0] HALF_P = (AW+1)'(1) << (abkf_pkg::FRAC_P - 1);

	logic [WW-1:0] ua_q;
	logic [PW-1:0] ub_q;
	logic [AW-1:0] acc_q;
	logic          neg_q, sh_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, fin_q, done_q;
	logic signed [RW-1:0] res_q;

	logic [WW-1:0] ua, ub;
	logic [AW:0]   rnd, shd;
	logic [WW+1:0] lim_mag;
	logic signed [RW-1:0] mres;

	assign ua = a[WW-1] ? (~a + 1'b1) : a;
	assign ub = b[WW-1] ? (~b + 1'b1) : b;

	always_comb begin
		rnd = {1'b0, acc_q} + (sh_q ? HALF_P : HALF_T);
		shd = sh_q ? (rnd >> abkf_pkg::FRAC_P) : (rnd >> abkf_pkg::FRAC_T);
		lim_mag = (shd > LIM) ? LIM[WW+1:0] : shd[WW+1:0];
		mres = neg_q ? -$signed(RW'(lim_mag)) : $signed(RW'(lim_mag));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ND);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= ua;
			ub_q  <= PW'(ub);
			acc_q <= '0;
			neg_q <= a[WW-1] ^ b[WW-1];
			sh_q  <= frac_p;
		end else if (busy_q) begin
			acc_q <= (acc_q << abkf_pkg::DIGIT_W)
				+ AW'(ua_q * ub_q[PW-1 -: abkf_pkg::DIGIT_W]);
			ub_q  <= ub_q << abkf_pkg::DIGIT_W;
		end
		if (fin_q) begin
			res_q <= mres;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* rtl/abkf_div.sv */
// ----------------------------------------------------------------------------
// abkf_div: restoring divider for the Kalman gains
// Computes (num << 24) / den, truncated toward zero, one bit per cycle,
// saturated to the state width; zero divisor gives zero.
// ----------------------------------------------------------------------------
module abkf_div #(
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [DATA_WIDTH-1:0] num,
	input  logic signed [((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 1:0] den,
	output logic done,
	output logic signed [DATA_WIDTH-1:0] res
);

	localparam int SW = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 2;
	localparam int NQ = DATA_WIDTH + abkf_pkg::FRAC_P;
	localparam int CW = $clog2(NQ + 1);
	localparam logic [NQ-1:0] MAXQ = NQ'({(DATA_WIDTH-1){1'b1}});

	logic [NQ-1:0] dvd_q, q_q;
	logic [SW-1:0] rem_q, ud_q;
	logic          neg_q, zero_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, fin_q, done_q;
	logic signed [DATA_WIDTH-1:0] res_q;

	logic [DATA_WIDTH-1:0] un;
	logic [SW-1:0]         ud;
	logic [SW:0]           trial, diff;
	logic                  ge;

	assign un = num[DATA_WIDTH-1] ? (~num + 1'b1) : num;
	assign ud = den[SW-1] ? (~den + 1'b1) : den;

	always_comb begin
		trial = {rem_q, dvd_q[NQ-1]};
		ge    = trial >= {1'b0, ud_q};
		diff  = trial - {1'b0, ud_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NQ);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {un, {abkf_pkg::FRAC_P{1'b0}}};
			q_q    <= '0;
			rem_q  <= '0;
			ud_q   <= ud;
			neg_q  <= num[DATA_WIDTH-1] ^ den[SW-1];
			zero_q <= (den == '0);
		end else if (busy_q) begin
			rem_q <= ge ? diff[SW-1:0] : trial[SW-1:0];
			q_q   <= {q_q[NQ-2:0], ge};
			dvd_q <= dvd_q << 1;
		end
		if (fin_q) begin
			if (zero_q) begin
				res_q <= '0;
			end else if (!neg_q) begin
				res_q <= (q_q > MAXQ) ? $signed({1'b0, {(DATA_WIDTH-1){1'b1}}})
					: $signed(q_q[DATA_WIDTH-1:0]);
			end else begin
				res_q <= (q_q > MAXQ + 1'b1) ? $signed({1'b1, {(DATA_WIDTH-1){1'b0}}})
					: -$signed(q_q[DATA_WIDTH-1:0]);
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* rtl/abkf_dp.sv */
// ----------------------------------------------------------------------------
// abkf_dp: filter datapath
// State and covariance registers, config registers, operand selection and
// write-back around one shared multiplier and one divider.
// ----------------------------------------------------------------------------
module abkf_dp #(
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  abkf_pkg::cmd_t     cmd,
	output abkf_pkg::status_t  status,
	input  abkf_pkg::in_item_t in_data,
	output abkf_pkg::out_item_t out_data,
	input  logic cfg_we,
	input  logic [abkf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int DW = DATA_WIDTH;
	localparam int WW = ((DATA_WIDTH > 33) ? DATA_WIDTH : 33) + 3;
	localparam int RW = WW + 3;
	localparam int SW = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 2;
	localparam logic signed [RW:0] MAXV = {{(RW+2-DW){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [RW:0] MINV = {{(RW+2-DW){1'b1}}, {(DW-1){1'b0}}};
	localparam logic signed [RW:0] MAX32 = {{(RW-30){1'b0}}, {31{1'b1}}};
	localparam logic signed [RW:0] MIN32 = {{(RW-30){1'b1}}, {31{1'b0}}};
	localparam logic signed [DW-1:0] ONE_P = DW'(1) << abkf_pkg::FRAC_P;

	function automatic logic signed [DW-1:0] sat_dw(input logic signed [RW:0] v);
		logic signed [DW-1:0] r;
		if (v > MAXV)      r = MAXV[DW-1:0];
		else if (v < MINV) r = MINV[DW-1:0];
		else               r = v[DW-1:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [RW:0] v);
		logic signed [31:0] r;
		if (v > MAX32)      r = MAX32[31:0];
		else if (v < MIN32) r = MIN32[31:0];
		else                r = v[31:0];
		return r;
	endfunction

	logic [31:0] qa_q, qb_q, r_q;
	logic signed [DW-1:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	abkf_pkg::in_item_t in_q;
	logic signed [WW-1:0] dp11_q, y_q;
	logic signed [DW-1:0] k0_q, k1_q, p00o_q, p01o_q;
	abkf_pkg::out_item_t out_q;

	logic signed [WW-1:0] ma, mb, dt_w, t_w;
	logic                 mfrac, is_div, mul_start, div_start, mul_done, div_done;
	logic signed [RW-1:0] mres;
	logic signed [DW-1:0] rate, num, dres;
	logic signed [SW-1:0] den;

	assign dt_w = $signed({{(WW-16){1'b0}}, in_q.step_time});
	assign t_w  = dp11_q - WW'(p01_q) - WW'(p10_q) + $signed({{(WW-32){1'b0}}, qa_q});
	assign rate = sat_dw((RW+1)'(in_q.measured_rate) - (RW+1)'(bias_q));
	assign num  = (cmd.op == abkf_pkg::OP_K0) ? p00_q : p10_q;
	assign den  = SW'(p00_q) + $signed({{(SW-32){1'b0}}, r_q});
	assign is_div = (cmd.op == abkf_pkg::OP_K0) || (cmd.op == abkf_pkg::OP_K1);
	assign mul_start = cmd.start && !is_div;
	assign div_start = cmd.start && is_div;

	always_comb begin
		ma = '0;
		mb = '0;
		mfrac = 1'b0;
		case (cmd.op)
			abkf_pkg::OP_ANGLE_PRED: begin ma = dt_w; mb = WW'(rate); end
			abkf_pkg::OP_DP11:       begin ma = dt_w; mb = WW'(p11_q); end
			abkf_pkg::OP_P00_PRED:   begin ma = dt_w; mb = t_w; end
			abkf_pkg::OP_P11_PRED: begin
				ma = $signed({{(WW-32){1'b0}}, qb_q});
				mb = dt_w;
			end
			abkf_pkg::OP_A_CORR:   begin ma = WW'(k0_q); mb = y_q; mfrac = 1'b1; end
			abkf_pkg::OP_B_CORR:   begin ma = WW'(k1_q); mb = y_q; mfrac = 1'b1; end
			abkf_pkg::OP_P00_CORR: begin ma = WW'(k0_q); mb = WW'(p00o_q); mfrac = 1'b1; end
			abkf_pkg::OP_P01_CORR: begin ma = WW'(k0_q); mb = WW'(p01o_q); mfrac = 1'b1; end
			abkf_pkg::OP_P10_CORR: begin ma = WW'(k1_q); mb = WW'(p00o_q); mfrac = 1'b1; end
			abkf_pkg::OP_P11_CORR: begin ma = WW'(k1_q); mb = WW'(p01o_q); mfrac = 1'b1; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	abkf_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .frac_p(mfrac),
		.a(ma), .b(mb), .done(mul_done), .res(mres)
	);

	abkf_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num), .den(den), .done(div_done), .res(dres)
	);

	assign status.done = mul_done | div_done;

	// filter state and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q   <= abkf_pkg::ANGLE_NOISE_RST;
			qb_q   <= abkf_pkg::BIAS_NOISE_RST;
			r_q    <= abkf_pkg::MEAS_NOISE_RST;
			ang_q  <= '0;
			bias_q <= '0;
			p00_q  <= ONE_P;
			p01_q  <= '0;
			p10_q  <= '0;
			p11_q  <= ONE_P;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					abkf_pkg::REG_ANGLE_NOISE: qa_q <= cfg_data;
					abkf_pkg::REG_BIAS_NOISE:  qb_q <= cfg_data;
					abkf_pkg::REG_MEAS_NOISE:  r_q  <= cfg_data;
					default: ;
				endcase
			end
			if (status.done) begin
				case (cmd.op)
					abkf_pkg::OP_ANGLE_PRED,
					abkf_pkg::OP_A_CORR:
						ang_q <= sat_dw((RW+1)'(ang_q) + (RW+1)'(mres));
					abkf_pkg::OP_B_CORR:
						bias_q <= sat_dw((RW+1)'(bias_q) + (RW+1)'(mres));
					abkf_pkg::OP_P00_PRED: begin
						p00_q <= sat_dw((RW+1)'(p00_q) + (RW+1)'(mres));
						p01_q <= sat_dw((RW+1)'(p01_q) - (RW+1)'(dp11_q));
						p10_q <= sat_dw((RW+1)'(p10_q) - (RW+1)'(dp11_q));
					end
					abkf_pkg::OP_P11_PRED:
						p11_q <= sat_dw((RW+1)'(p11_q) + (RW+1)'(mres));
					abkf_pkg::OP_P00_CORR:
						p00_q <= sat_dw((RW+1)'(p00_q) - (RW+1)'(mres));
					abkf_pkg::OP_P01_CORR:
						p01_q <= sat_dw((RW+1)'(p01_q) - (RW+1)'(mres));
					abkf_pkg::OP_P10_CORR:
						p10_q <= sat_dw((RW+1)'(p10_q) - (RW+1)'(mres));
					abkf_pkg::OP_P11_CORR:
						p11_q <= sat_dw((RW+1)'(p11_q) - (RW+1)'(mres));
					default: ;
				endcase
			end
		end
	end

	// per-item scratch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
		if (status.done) begin
			case (cmd.op)
				abkf_pkg::OP_DP11: dp11_q <= mres[WW-1:0];
				abkf_pkg::OP_K0:   k0_q <= dres;
				abkf_pkg::OP_K1: begin
					// snapshot P and innovation before the update writes
					k1_q   <= dres;
					y_q    <= WW'(in_q.measured_angle) - WW'(ang_q);
					p00o_q <= p00_q;
					p01o_q <= p01_q;
				end
				default: ;
			endcase
		end
		if (cmd.emit) begin
			out_q.filtered_angle <= sat32((RW+1)'(ang_q));
			out_q.estimated_bias <= sat32((RW+1)'(bias_q));
		end
	end

	assign out_data = out_q;

endmodule

/* rtl/abkf_ctrl.sv */
// ----------------------------------------------------------------------------
// abkf_ctrl: filter sequencer
// Steps the datapath through the micro-op list, one unit run per op, and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module abkf_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  abkf_pkg::status_t status,
	output abkf_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t        state_q;
	abkf_pkg::op_t op_q;
	logic          start_q, out_valid_q;
	logic          accept, slot_free, emit;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign emit      = (state_q == ST_FINISH) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= abkf_pkg::OP_ANGLE_PRED;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= abkf_pkg::OP_ANGLE_PRED;
						start_q <= 1'b1;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (status.done) begin
						if (op_q == abkf_pkg::OP_P11_CORR) begin
							state_q <= ST_FINISH;
						end else begin
							op_q    <= abkf_pkg::op_t'(op_q + 1'b1);
							start_q <= 1'b1;
						end
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.load  = accept;
	assign cmd.start = start_q;
	assign cmd.emit  = emit;
	assign cmd.op    = op_q;

endmodule

/* rtl/angle_bias_kalman_filter.sv */
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter: two-state (angle, gyro bias) Kalman filter
// Fixed-point predict/update per sample; one result per request.
//
//   channel  signals                             direction
//   in       in_valid, in_stall, in_data         request in
//   out      out_valid, out_stall, out_data      result out
//   cfg      cfg_valid, cfg_ready, cfg_index,    register write in
//            cfg_data
//
// One request at a time. Ten products on a 4-bit-per-cycle multiplier and two
// gains on a 1-bit-per-cycle divider, plus sequencing between the micro-ops.
// Reset loads noise defaults, zero angle/bias, P = identity.
// A held result does not block the next request; only the write of a new
// result waits on out_stall.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter #(
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  abkf_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output abkf_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [abkf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	abkf_pkg::cmd_t    cmd;
	abkf_pkg::status_t status;

	assign cfg_ready = 1'b1;

	abkf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .cmd(cmd)
	);

	abkf_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .status(status),
		.in_data(in_data), .out_data(out_data),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted but block not busy");

	a_done_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> in_stall)
		else $error("unit finished while sequencer idle");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in flight");

	a_single_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !cmd.start)
		else $error("back-to-back unit starts");
`endif

endmodule
